// ===== hw/rtl/b32e_pkg.sv =====
// Shared types and constants for the streaming base32 encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.

package b32e_pkg;

  localparam logic [7:0] PAD_CHAR      = 8'h3D;  // '='
  localparam logic [4:0] SYM_MASK      = 5'h1F;
  localparam int         JOB_SYMS      = 3;      // two data characters plus a tail

  // Byte position codes within a 5-byte group.
  localparam logic [2:0] POS_0 = 3'd0;
  localparam logic [2:0] POS_1 = 3'd1;
  localparam logic [2:0] POS_2 = 3'd2;
  localparam logic [2:0] POS_3 = 3'd3;
  localparam logic [2:0] POS_4 = 3'd4;

  // One byte's worth of output work: a few 5-bit codes, then '=' padding.
  typedef struct packed {
    logic [JOB_SYMS-1:0][4:0] codes;
    logic [1:0]               nsym;
    logic [2:0]               npad;
    logic                     last;
  } b32e_job_t;

  // Standard alphabet: A..Z for 0..25, 2..7 for 26..31.
  function automatic logic [7:0] b32e_char(input logic [4:0] code);
    logic [7:0] wide;
    wide = {3'b000, code & SYM_MASK};
    if (code < 5'd26) begin
      return 8'h41 + wide;
    end
    return 8'h18 + wide;
  endfunction

endpackage

// ===== hw/rtl/b32e_front.sv =====
// Front end of the base32 encoder: holds leftover bits and group position,
// and turns each accepted byte into a job record. Depends on b32e_pkg.

module b32e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  output b32e_pkg::b32e_job_t job
);
  import b32e_pkg::*;

  logic [3:0] leftover_r, leftover_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [4:0] c0, c1, tail;
  logic       two_data, has_tail;
  logic [2:0] pad_last;
  logic [3:0] left_keep;

  always_comb begin
    c0        = data_byte[7:3];
    c1        = 5'd0;
    tail      = {data_byte[2:0], 2'b00};
    two_data  = 1'b0;
    has_tail  = 1'b1;
    pad_last  = 3'd6;
    left_keep = {1'b0, data_byte[2:0]};
    pos_nxt   = POS_1;
    unique case (pos_r)
      POS_1: begin
        c0        = {leftover_r[2:0], data_byte[7:6]};
        c1        = data_byte[5:1];
        tail      = {data_byte[0], 4'b0000};
        two_data  = 1'b1;
        pad_last  = 3'd4;
        left_keep = {3'b000, data_byte[0]};
        pos_nxt   = POS_2;
      end
      POS_2: begin
        c0        = {leftover_r[0], data_byte[7:4]};
        tail      = {data_byte[3:0], 1'b0};
        pad_last  = 3'd3;
        left_keep = data_byte[3:0];
        pos_nxt   = POS_3;
      end
      POS_3: begin
        c0        = {leftover_r[3:0], data_byte[7]};
        c1        = data_byte[6:2];
        tail      = {data_byte[1:0], 3'b000};
        two_data  = 1'b1;
        pad_last  = 3'd1;
        left_keep = {2'b00, data_byte[1:0]};
        pos_nxt   = POS_4;
      end
      POS_4: begin
        c0        = {leftover_r[1:0], data_byte[7:5]};
        c1        = data_byte[4:0];
        has_tail  = 1'b0;
        two_data  = 1'b1;
        pad_last  = 3'd0;
        left_keep = 4'd0;
        pos_nxt   = POS_0;
      end
      default: begin
        // Position zero; unreachable codes behave the same way.
      end
    endcase

    job.codes[0] = c0;
    job.codes[1] = two_data ? c1 : tail;
    job.codes[2] = tail;
    job.nsym     = {1'b0, 1'b1} + {1'b0, two_data}
                   + {1'b0, end_of_message & has_tail};
    job.npad     = end_of_message ? pad_last : 3'd0;
    job.last     = end_of_message;

    leftover_nxt = end_of_message ? 4'd0 : left_keep;
    if (end_of_message) begin
      pos_nxt = POS_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leftover_r <= 4'd0;
      pos_r      <= POS_0;
    end else if (accept) begin
      leftover_r <= leftover_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

// ===== hw/rtl/b32e_queue.sv =====
// Two-entry job queue between the encoder front and back ends.
// Depends on b32e_pkg for the job record type.

module b32e_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  b32e_pkg::b32e_job_t wr_job,
  output logic                q_full,
  input  logic                rd_en,
  output logic                q_valid,
  output b32e_pkg::b32e_job_t rd_job
);
  import b32e_pkg::*;

  b32e_job_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !(rd_en && q_valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!wr_en && rd_en && q_valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("job queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && q_full && !rd_en))
    else $error("job written into a full queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/b32e_back.sv =====
// Back end of the base32 encoder: walks each job one character per cycle, unless
// pop stalls it, into the output register. Depends on b32e_pkg.

module b32e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  b32e_pkg::b32e_job_t job,
  output logic                q_pop,
  input  logic                pop,
  output logic                out_valid,
  output logic [7:0]          symbol_char,
  output logic                final_symbol
);
  import b32e_pkg::*;

  logic [2:0] idx_r;
  logic [3:0] total;
  logic       load, job_done;
  logic       out_valid_r;
  logic [7:0] char_r, char_nxt;
  logic       final_r;

  assign total    = {2'b00, job.nsym} + {1'b0, job.npad};
  assign load     = q_valid && (!out_valid_r || pop);
  assign job_done = ({1'b0, idx_r} == total - 4'd1);
  assign q_pop    = load && job_done;

  always_comb begin
    char_nxt = PAD_CHAR;
    if ({1'b0, idx_r} < {2'b00, job.nsym}) begin
      char_nxt = b32e_char(job.codes[idx_r[1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r  <= char_nxt;
      final_r <= job.last && job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= job_done ? 3'd0 : idx_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign symbol_char  = char_r;
  assign final_symbol = final_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ({1'b0, idx_r} < total))
    else $error("character index past end of job");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (idx_r == 3'd0))
    else $error("index not cleared after a finished job");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !load) |=> $stable(idx_r))
    else $error("index moved while the output was stalled");

endmodule

// ===== hw/rtl/base32_stream_encoder.sv =====
// Top level of the streaming base32 (standard alphabet) encoder.
// Instantiates b32e_front, b32e_queue and b32e_back; depends on b32e_pkg.
//
//   Channel  Ports                                   Handshake
//   input    in_data_byte, in_end_of_message         push / full
//   result   out_symbol_char, out_final_symbol       empty / pop
//
// A byte is classified by the front end in the cycle it is accepted and stored
// as one job in a two-entry queue. The back end emits one character per cycle,
// unless pop stalls it, so a byte yields 1 or 2 characters (up to 8 on the last
// byte of a message); this output rate sets throughput. The first character is
// registered from the queued job. Reset (synchronous, active low) clears control state.
// A stalled result (pop low) holds the back end; the front accepts until the queue fills.

module base32_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_symbol_char,
  output logic       out_final_symbol
);
  import b32e_pkg::*;

  b32e_job_t new_job;
  b32e_job_t head_job;
  logic      accept;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      out_valid;

  // A transaction is accepted whenever push is high and the job queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  b32e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .job            (new_job)
  );

  b32e_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_job  (new_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .rd_job  (head_job)
  );

  // The back end refills the output register in the same cycle it is popped, if a
  // job is queued, so characters stream at one per cycle while pop stays high.
  b32e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .job          (head_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .out_valid    (out_valid),
    .symbol_char  (out_symbol_char),
    .final_symbol (out_final_symbol)
  );

  assign empty = !out_valid;

endmodule
